### hdl/qfno_pkg.sv
// ============================================================================
// qfno_pkg
// Shared types and constants of the quad face node order check block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package qfno_pkg;

    localparam int ID_W              = 12;
    localparam int POS_W             = 16;
    localparam int TOL_W             = 64;
    localparam int NODE_DEPTH_DEF    = 4096;
    localparam int COORD_WIDTH_DEF   = 16;
    localparam int QUEUE_DEPTH       = 2;
    localparam int FACE_NODES        = 4;

    // Result status codes.
    localparam logic [1:0] ST_QUAD   = 2'd0;
    localparam logic [1:0] ST_TRI    = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;
    localparam logic [1:0] ST_WRITE  = 2'd3;

    // Request type codes.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [2:0]       node_count;
        logic [ID_W-1:0]  node_a;
        logic [ID_W-1:0]  node_b;
        logic [ID_W-1:0]  node_c;
        logic [ID_W-1:0]  node_d;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
    } req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] out_node_a;
        logic [ID_W-1:0] out_node_b;
        logic [ID_W-1:0] out_node_c;
        logic [ID_W-1:0] out_node_d;
    } rsp_t;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_TRI,
        KIND_QUAD
    } cmd_kind_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        cmd_kind_t                        kind;
        logic [FACE_NODES-1:0][ID_W-1:0]  ids;
    } cmd_t;

endpackage

`default_nettype wire

### hdl/qfno_ram.sv
// ============================================================================
// qfno_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qfno_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/qfno_fifo.sv
// ============================================================================
// qfno_fifo
// Short register queue that decouples the classifier from the engine.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qfno_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = qfno_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= in_data;
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/qfno_front.sv
// ============================================================================
// qfno_front
// Accepts requests, sorts face node ids and reduces ids to store addresses.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qfno_front #(
    parameter int NODE_DEPTH  = qfno_pkg::NODE_DEPTH_DEF,
    parameter int COORD_WIDTH = qfno_pkg::COORD_WIDTH_DEF,
    parameter int ADW         = $clog2(NODE_DEPTH)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire qfno_pkg::req_t                  s_data,
    output logic                                 o_valid,
    input  wire logic                            o_ready,
    output qfno_pkg::cmd_t                       o_cmd,
    output logic [qfno_pkg::FACE_NODES*ADW-1:0]  o_addr,
    output logic [3*COORD_WIDTH-1:0]             o_wdata
);

    localparam int IW    = qfno_pkg::ID_W;
    localparam int PW    = qfno_pkg::POS_W;
    localparam int NF    = qfno_pkg::FACE_NODES;
    // Reciprocal of the depth for the id reduction; the quotient estimate is
    // low by at most one, which the compare and subtract below corrects.
    localparam int RECIP = (2 ** 24) / NODE_DEPTH;

    logic                     f_valid_reg;
    qfno_pkg::cmd_t           f_cmd_reg;
    logic [NF-1:0][IW-1:0]    f_q_reg;
    logic [3*PW-1:0]          f_pos_reg;

    qfno_pkg::cmd_t           cmd_in;
    logic [NF-1:0][IW-1:0]    q_in;
    logic [IW-1:0]            srt [NF];
    logic [IW-1:0]            tmp;
    logic [47:0]              qprod;
    logic [31:0]              rem;
    logic [COORD_WIDTH+PW-1:0] ext;
    logic                     accept;

    assign s_ready = !f_valid_reg || o_ready;
    assign accept  = s_valid && s_ready;
    assign o_valid = f_valid_reg;
    assign o_cmd   = f_cmd_reg;

    // Sorting network on four ids; a triangle sorts with its fourth slot
    // pinned at the largest id so that it stays last.
    always_comb begin
        tmp    = '0;
        srt[0] = s_data.node_a;
        srt[1] = s_data.node_b;
        srt[2] = s_data.node_c;
        srt[3] = (s_data.node_count < 3'd4) ? {IW{1'b1}} : s_data.node_d;
        if (srt[0] > srt[1]) begin tmp = srt[0]; srt[0] = srt[1]; srt[1] = tmp; end
        if (srt[2] > srt[3]) begin tmp = srt[2]; srt[2] = srt[3]; srt[3] = tmp; end
        if (srt[0] > srt[2]) begin tmp = srt[0]; srt[0] = srt[2]; srt[2] = tmp; end
        if (srt[1] > srt[3]) begin tmp = srt[1]; srt[1] = srt[3]; srt[3] = tmp; end
        if (srt[1] > srt[2]) begin tmp = srt[1]; srt[1] = srt[2]; srt[2] = tmp; end

        if (s_data.req_type == qfno_pkg::REQ_WRITE) begin
            cmd_in.kind = qfno_pkg::KIND_WRITE;
            cmd_in.ids  = {{(3*IW){1'b0}}, s_data.node_a};
        end else if (s_data.node_count < 3'd4) begin
            cmd_in.kind = qfno_pkg::KIND_TRI;
            cmd_in.ids  = {{IW{1'b0}}, srt[2], srt[1], srt[0]};
        end else begin
            cmd_in.kind = qfno_pkg::KIND_QUAD;
            cmd_in.ids  = {srt[3], srt[2], srt[1], srt[0]};
        end

        for (int i = 0; i < NF; i++) begin
            qprod   = 48'(cmd_in.ids[i]) * 48'(RECIP);
            q_in[i] = qprod[35:24];
        end
    end

    // Remainder from the registered quotient estimate.
    always_comb begin
        o_addr = '0;
        for (int i = 0; i < NF; i++) begin
            rem = 32'(f_cmd_reg.ids[i]) - 32'(f_q_reg[i]) * 32'(NODE_DEPTH);
            if (rem >= 32'(NODE_DEPTH)) begin
                rem = rem - 32'(NODE_DEPTH);
            end
            o_addr[i*ADW +: ADW] = rem[ADW-1:0];
        end
        for (int k = 0; k < 3; k++) begin
            ext = {{COORD_WIDTH{1'b0}}, f_pos_reg[(2-k)*PW +: PW]};
            o_wdata[k*COORD_WIDTH +: COORD_WIDTH] = ext[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                f_valid_reg <= 1'b1;
                f_cmd_reg   <= cmd_in;
                f_q_reg     <= q_in;
                f_pos_reg   <= {s_data.pos_x, s_data.pos_y, s_data.pos_z};
            end else if (o_ready) begin
                f_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/qfno_mul.sv
// ============================================================================
// qfno_mul
// Iterative signed multiplier, four bits of the multiplier per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qfno_mul #(
    parameter int MW = 35
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [MW-1:0] op_a,
    input  wire logic signed [MW-1:0] op_b,
    output logic                      done,
    output logic signed [2*MW-1:0]    prod
);

    localparam int NDIG  = (MW + 3) / 4;
    localparam int CNT_W = $clog2(NDIG + 1);

    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic [2*MW-1:0]   amag_reg;
    logic [MW-1:0]     bmag_reg;
    logic [2*MW-1:0]   acc_reg;
    logic signed [2*MW-1:0] prod_reg;

    logic [MW-1:0]     amag;
    logic [MW-1:0]     bmag;
    logic [2*MW-1:0]   pp;

    assign amag = op_a[MW-1] ? (~op_a + 1'b1) : op_a;
    assign bmag = op_b[MW-1] ? (~op_b + 1'b1) : op_b;
    assign pp   = amag_reg * {{(2*MW-4){1'b0}}, bmag_reg[3:0]};
    assign done = done_reg;
    assign prod = prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                neg_reg  <= op_a[MW-1] ^ op_b[MW-1];
                amag_reg <= {{MW{1'b0}}, amag};
                bmag_reg <= bmag;
                acc_reg  <= '0;
            end else if (busy_reg) begin
                acc_reg  <= acc_reg + pp;
                amag_reg <= amag_reg << 4;
                bmag_reg <= bmag_reg >> 4;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NDIG - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
                prod_reg <= neg_reg ? $signed(~acc_reg + 1'b1) : $signed(acc_reg);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/qfno_back.sv
// ============================================================================
// qfno_back
// Executes commands: store writes, triangle results and the ordering tests.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qfno_back #(
    parameter int NODE_DEPTH  = qfno_pkg::NODE_DEPTH_DEF,
    parameter int COORD_WIDTH = qfno_pkg::COORD_WIDTH_DEF,
    parameter int ADW         = $clog2(NODE_DEPTH)
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                q_valid,
    output logic                                     q_ready,
    input  wire qfno_pkg::cmd_t                      q_cmd,
    input  wire logic [qfno_pkg::FACE_NODES*ADW-1:0] q_addr,
    input  wire logic [3*COORD_WIDTH-1:0]            q_wdata,
    input  wire logic [qfno_pkg::TOL_W-1:0]          tol,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output qfno_pkg::rsp_t                           m_data
);

    localparam int CW  = COORD_WIDTH;
    localparam int NF  = qfno_pkg::FACE_NODES;
    localparam int IW  = qfno_pkg::ID_W;
    localparam int VW  = CW + 1;
    localparam int AW  = 2 * VW + 1;
    localparam int MW  = (AW > 33) ? AW : 33;
    localparam int PW  = 2 * MW;
    localparam int ACW = PW + 2;
    localparam int XW  = 2 * AW + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_RUN, S_WAIT, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_A1, PH_A2, PH_DOT, PH_CX, PH_SQ
    } phase_t;

    typedef enum logic [1:0] {
        ORD_0123, ORD_0213, ORD_0132
    } ord_t;

    typedef enum logic [1:0] {
        ACC_LOAD, ACC_ADD, ACC_SUB
    } acc_mode_t;

    state_t                 state_reg;
    phase_t                 phase_reg;
    ord_t                   ord_reg;
    logic [2:0]             sub_reg;
    logic [2:0]             rd_cnt_reg;
    logic [NF-1:0][IW-1:0]  cur_ids_reg;
    logic [ADW-1:0]         cur_addr_reg [NF];
    logic signed [CW-1:0]   pos_reg [NF][3];
    logic signed [AW-1:0]   a1_reg [3];
    logic signed [AW-1:0]   a2_reg [3];
    logic signed [XW-1:0]   c_reg [3];
    logic signed [ACW-1:0]  acc_reg;
    qfno_pkg::rsp_t         res_reg;
    logic                   m_valid_reg;
    qfno_pkg::rsp_t         m_data_reg;

    logic                   pop;
    logic                   ram_we;
    logic [ADW-1:0]         ram_raddr;
    logic [3*CW-1:0]        ram_rdata;
    logic [1:0]             pidx [1:3];
    logic signed [VW-1:0]   vv [1:3][3];
    logic signed [MW-1:0]   u_op [3];
    logic signed [MW-1:0]   w_op [3];
    logic [1:0]             jj;
    logic [1:0]             i1;
    logic [1:0]             i2;
    logic signed [XW-1:0]   csel;
    logic [XW-1:0]          cmag;
    logic                   big;
    logic signed [MW-1:0]   mul_a;
    logic signed [MW-1:0]   mul_b;
    acc_mode_t              mode;
    logic                   mul_start;
    logic                   mul_done;
    logic signed [PW-1:0]   mul_prod;
    logic signed [ACW-1:0]  pext;
    logic signed [ACW-1:0]  acc_sum;
    logic                   sub_last;
    logic                   sq_pass;
    ord_t                   ord_succ;
    logic [2:0]             rd_prev;

    assign pop     = (state_reg == S_IDLE) && q_valid;
    assign q_ready = (state_reg == S_IDLE);
    assign ram_we  = pop && (q_cmd.kind == qfno_pkg::KIND_WRITE);
    assign ram_raddr = cur_addr_reg[rd_cnt_reg[1:0]];
    assign rd_prev = rd_cnt_reg - 3'd1;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    qfno_ram #(
        .WIDTH (3 * CW),
        .DEPTH (NODE_DEPTH),
        .ADDR_W(ADW)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(q_addr[ADW-1:0]),
        .wdata(q_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    qfno_mul #(
        .MW(MW)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    // Corner positions of the current ordering relative to its first node.
    always_comb begin
        case (ord_reg)
            ORD_0213: begin pidx[1] = 2'd2; pidx[2] = 2'd1; pidx[3] = 2'd3; end
            ORD_0132: begin pidx[1] = 2'd1; pidx[2] = 2'd3; pidx[3] = 2'd2; end
            default:  begin pidx[1] = 2'd1; pidx[2] = 2'd2; pidx[3] = 2'd3; end
        endcase
        case (ord_reg)
            ORD_0123: ord_succ = ORD_0213;
            default:  ord_succ = ORD_0132;
        endcase
        for (int i = 1; i <= 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                vv[i][k] = VW'(pos_reg[pidx[i]][k]) - VW'(pos_reg[0][k]);
            end
        end
    end

    // Operand selection for the step in progress.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (phase_reg)
                PH_A1: begin u_op[k] = MW'(vv[1][k]); w_op[k] = MW'(vv[2][k]); end
                PH_A2: begin u_op[k] = MW'(vv[2][k]); w_op[k] = MW'(vv[3][k]); end
                default: begin u_op[k] = MW'(a1_reg[k]); w_op[k] = MW'(a2_reg[k]); end
            endcase
        end
        jj = sub_reg[2:1];
        case (jj)
            2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
            2'd2:    begin i1 = 2'd0; i2 = 2'd1; end
            default: begin i1 = 2'd1; i2 = 2'd2; end
        endcase
        csel = c_reg[sub_reg[1:0]];
        cmag = csel[XW-1] ? XW'(-csel) : csel;
        big  = |cmag[XW-1:32];
        case (phase_reg)
            PH_DOT: begin
                mul_a = u_op[sub_reg[1:0]];
                mul_b = w_op[sub_reg[1:0]];
                mode  = (sub_reg == 3'd0) ? ACC_LOAD : ACC_ADD;
            end
            PH_SQ: begin
                mul_a = MW'($signed({1'b0, cmag[31:0]}));
                mul_b = MW'($signed({1'b0, cmag[31:0]}));
                mode  = (sub_reg == 3'd0) ? ACC_LOAD : ACC_ADD;
            end
            default: begin
                mul_a = sub_reg[0] ? u_op[i2] : u_op[i1];
                mul_b = sub_reg[0] ? w_op[i1] : w_op[i2];
                mode  = sub_reg[0] ? ACC_SUB : ACC_LOAD;
            end
        endcase
        pext = ACW'(mul_prod);
        case (mode)
            ACC_ADD: acc_sum = acc_reg + pext;
            ACC_SUB: acc_sum = acc_reg - pext;
            default: acc_sum = pext;
        endcase
        sub_last  = (phase_reg == PH_DOT || phase_reg == PH_SQ) ? (sub_reg == 3'd2)
                                                                : (sub_reg == 3'd5);
        sq_pass   = (acc_sum[ACW-1:64] == '0) && (acc_sum[63:0] <= tol);
        mul_start = (state_reg == S_RUN) && !((phase_reg == PH_SQ) && big);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cur_ids_reg <= q_cmd.ids;
                        for (int i = 0; i < NF; i++) begin
                            cur_addr_reg[i] <= q_addr[i*ADW +: ADW];
                        end
                        rd_cnt_reg <= '0;
                        case (q_cmd.kind)
                            qfno_pkg::KIND_WRITE: begin
                                res_reg.status     <= qfno_pkg::ST_WRITE;
                                res_reg.out_node_a <= '0;
                                res_reg.out_node_b <= '0;
                                res_reg.out_node_c <= '0;
                                res_reg.out_node_d <= '0;
                                state_reg <= S_DONE;
                            end
                            qfno_pkg::KIND_TRI: begin
                                res_reg.status     <= qfno_pkg::ST_TRI;
                                res_reg.out_node_a <= q_cmd.ids[0];
                                res_reg.out_node_b <= q_cmd.ids[1];
                                res_reg.out_node_c <= q_cmd.ids[2];
                                res_reg.out_node_d <= '0;
                                state_reg <= S_DONE;
                            end
                            default: begin
                                state_reg <= S_LOAD;
                            end
                        endcase
                    end
                end
                S_LOAD: begin
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                    if (rd_cnt_reg != 3'd0) begin
                        for (int k = 0; k < 3; k++) begin
                            pos_reg[rd_prev[1:0]][k] <= ram_rdata[k*CW +: CW];
                        end
                    end
                    if (rd_cnt_reg == 3'd4) begin
                        ord_reg   <= ORD_0123;
                        phase_reg <= PH_A1;
                        sub_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    if ((phase_reg == PH_SQ) && big) begin
                        if (ord_reg == ORD_0132) begin
                            res_reg.status     <= qfno_pkg::ST_NONE;
                            res_reg.out_node_a <= cur_ids_reg[0];
                            res_reg.out_node_b <= cur_ids_reg[1];
                            res_reg.out_node_c <= cur_ids_reg[2];
                            res_reg.out_node_d <= cur_ids_reg[3];
                            state_reg <= S_DONE;
                        end else begin
                            ord_reg   <= ord_succ;
                            phase_reg <= PH_A1;
                            sub_reg   <= '0;
                        end
                    end else begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (mul_done) begin
                        acc_reg <= acc_sum;
                        if (sub_reg[0]) begin
                            case (phase_reg)
                                PH_A1: a1_reg[jj] <= AW'(acc_sum);
                                PH_A2: a2_reg[jj] <= AW'(acc_sum);
                                PH_CX: c_reg[jj]  <= XW'(acc_sum);
                                default: ;
                            endcase
                        end
                        if ((phase_reg == PH_DOT && sub_last && acc_sum[ACW-1]) ||
                            (phase_reg == PH_SQ && sub_last && !sq_pass)) begin
                            if (ord_reg == ORD_0132) begin
                                res_reg.status     <= qfno_pkg::ST_NONE;
                                res_reg.out_node_a <= cur_ids_reg[0];
                                res_reg.out_node_b <= cur_ids_reg[1];
                                res_reg.out_node_c <= cur_ids_reg[2];
                                res_reg.out_node_d <= cur_ids_reg[3];
                                state_reg <= S_DONE;
                            end else begin
                                ord_reg   <= ord_succ;
                                phase_reg <= PH_A1;
                                sub_reg   <= '0;
                                state_reg <= S_RUN;
                            end
                        end else if (phase_reg == PH_SQ && sub_last) begin
                            res_reg.status     <= qfno_pkg::ST_QUAD;
                            res_reg.out_node_a <= cur_ids_reg[0];
                            res_reg.out_node_b <= cur_ids_reg[pidx[1]];
                            res_reg.out_node_c <= cur_ids_reg[pidx[2]];
                            res_reg.out_node_d <= cur_ids_reg[pidx[3]];
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_RUN;
                            if (sub_last) begin
                                sub_reg <= '0;
                                case (phase_reg)
                                    PH_A1:   phase_reg <= PH_A2;
                                    PH_A2:   phase_reg <= PH_DOT;
                                    PH_DOT:  phase_reg <= PH_CX;
                                    default: phase_reg <= PH_SQ;
                                endcase
                            end else begin
                                sub_reg <= sub_reg + 3'd1;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/quad_face_node_order_check.sv
// ============================================================================
// quad_face_node_order_check
// Node position store with triangle sorting and quad ordering/planarity test.
// ============================================================================
// Usage:
//   The s_ channel carries requests. A write request (req_type 0) stores the
//   position of node_a; a check request sorts the face ids and, for a quad,
//   tries the orderings 0123, 0213 and 0132 until one has corner normals with
//   a non-negative dot product and a squared cross magnitude within the
//   tolerance. Every request gives exactly one result on the m_ channel.
//   The cfg_ channel writes the 64-bit tolerance; it is always ready and
//   resets to 1. Write it only while the block is idle.
//   A write or triangle request passes through the input register, the
//   queue, the engine's done state and the output register. A quad first
//   reads its four node positions from the store, then computes, per
//   ordering tried, up to 24 products on one shared multiplier (MW = 35 at
//   16-bit coordinates). The engine handles one request at a time; a
//   two-entry queue and an input register let new requests be accepted
//   while a result waits or the engine works.
//   Reset clears all control state and sets the tolerance to 1; the position
//   store keeps no reset value and needs no clearing pass. When the receiver
//   stalls, the result is held in the output register and the engine waits.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module quad_face_node_order_check #(
    parameter int NODE_DEPTH  = qfno_pkg::NODE_DEPTH_DEF,
    parameter int COORD_WIDTH = qfno_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [qfno_pkg::TOL_W-1:0]   cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire qfno_pkg::req_t               s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output qfno_pkg::rsp_t                    m_data
);

    localparam int ADW = $clog2(NODE_DEPTH);
    localparam int AFW = qfno_pkg::FACE_NODES * ADW;
    localparam int DFW = 3 * COORD_WIDTH;
    localparam int QW  = $bits(qfno_pkg::cmd_t) + AFW + DFW;

    logic [qfno_pkg::TOL_W-1:0] tol_reg;

    logic                 f_valid;
    logic                 f_ready;
    qfno_pkg::cmd_t       f_cmd;
    logic [AFW-1:0]       f_addr;
    logic [DFW-1:0]       f_wdata;

    logic                 b_valid;
    logic                 b_ready;
    logic [QW-1:0]        b_data;
    qfno_pkg::cmd_t       b_cmd;
    logic [AFW-1:0]       b_addr;
    logic [DFW-1:0]       b_wdata;

    // The tolerance register accepts a write in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= qfno_pkg::TOL_W'(1);
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    // Front: accept, classify, sort and reduce node ids to addresses.
    qfno_front #(
        .NODE_DEPTH (NODE_DEPTH),
        .COORD_WIDTH(COORD_WIDTH),
        .ADW        (ADW)
    ) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .o_valid(f_valid),
        .o_ready(f_ready),
        .o_cmd  (f_cmd),
        .o_addr (f_addr),
        .o_wdata(f_wdata)
    );

    // Command queue between the two halves.
    qfno_fifo #(
        .WIDTH(QW),
        .DEPTH(qfno_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  ({f_cmd, f_addr, f_wdata}),
        .out_valid(b_valid),
        .out_ready(b_ready),
        .out_data (b_data)
    );

    assign {b_cmd, b_addr, b_wdata} = b_data;

    // Back: store writes, result assembly and the ordering tests.
    qfno_back #(
        .NODE_DEPTH (NODE_DEPTH),
        .COORD_WIDTH(COORD_WIDTH),
        .ADW        (ADW)
    ) u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_valid(b_valid),
        .q_ready(b_ready),
        .q_cmd  (b_cmd),
        .q_addr (b_addr),
        .q_wdata(b_wdata),
        .tol    (tol_reg),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

`default_nettype wire

### hdl/qfno_checker.sv
// ============================================================================
// qfno_checker
// Port-level assertions on the result channel, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qfno_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire qfno_pkg::rsp_t m_data
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A write acknowledge carries no node ids.
    a_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == qfno_pkg::ST_WRITE |->
            m_data.out_node_a == '0 && m_data.out_node_b == '0 &&
            m_data.out_node_c == '0 && m_data.out_node_d == '0)
        else $error("write acknowledge with node ids");

    // A triangle comes back sorted with an empty fourth slot.
    a_tri: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == qfno_pkg::ST_TRI |->
            m_data.out_node_a <= m_data.out_node_b &&
            m_data.out_node_b <= m_data.out_node_c && m_data.out_node_d == '0)
        else $error("triangle result not sorted");

    // Any quad result starts with its smallest id; a failed one is fully sorted.
    a_quad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == qfno_pkg::ST_QUAD ||
                    m_data.status == qfno_pkg::ST_NONE) |->
            m_data.out_node_a <= m_data.out_node_b &&
            m_data.out_node_a <= m_data.out_node_c &&
            m_data.out_node_a <= m_data.out_node_d &&
            (m_data.status == qfno_pkg::ST_QUAD ||
             (m_data.out_node_b <= m_data.out_node_c &&
              m_data.out_node_c <= m_data.out_node_d)))
        else $error("quad result ordering broken");

endmodule

bind quad_face_node_order_check qfno_checker u_qfno_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

`default_nettype wire

### dv/tb_top.sv
// ============================================================================
// tb_top
// Self-checking testbench for the quad face node order check block.
// ============================================================================
// Node writes, triangle checks and quad checks are driven on the request
// channel in random bursts. A behavioral predictor in this file keeps its own
// copy of the node positions and the tolerance. For each accepted request it
// works out the expected result with wide exact integer arithmetic. Each
// result that comes back is compared field by field with the oldest
// prediction. Directed cases come first. Then the tolerance is swept and
// random traffic follows. Most quads come from coplanar node groups, so the
// ordering search gets deep coverage.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    // Wide enough that no product or sum in the plane test can wrap.
    typedef logic signed [191:0] wide_t;
    typedef logic [qfno_pkg::ID_W-1:0] id_t;

    localparam int NODES = qfno_pkg::NODE_DEPTH_DEF;

    // Request mix used by the random traffic.
    typedef enum int {
        MIX_PLANAR_GROUP,
        MIX_POOL_QUAD,
        MIX_TRIANGLE,
        MIX_WRITE
    } mix_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [qfno_pkg::TOL_W-1:0] cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    qfno_pkg::req_t             s_data = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    qfno_pkg::rsp_t             m_data;

    // Predictor state: node positions, which nodes were written, tolerance.
    logic signed [qfno_pkg::POS_W-1:0] node_coord [NODES][3];
    bit                                node_written [NODES];
    id_t                               written_ids [$];
    logic [qfno_pkg::TOL_W-1:0]        tolerance_sq = 64'd1;

    // Results still owed by the block, oldest first.
    qfno_pkg::rsp_t pending_results [$];
    int             error_count = 0;

    // Sender burst control and receiver stall control.
    int burst_left = 0;
    bit sender_steady = 1'b0;
    int hold_off_cycles = 0;
    int stall_mode = 0;
    int stall_phase = 0;

    always #2 aclk = ~aclk;

    quad_face_node_order_check DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void cross3(input wide_t u [3], input wide_t v [3],
                                   output wide_t r [3]);
        r[0] = u[1] * v[2] - u[2] * v[1];
        r[1] = u[2] * v[0] - u[0] * v[2];
        r[2] = u[0] * v[1] - u[1] * v[0];
    endfunction

    // True when the ordering p0..p3 has corner normals that point the same
    // way and are parallel within the tolerance.
    function automatic bit ordering_is_planar(input id_t p [4]);
        wide_t   vec [4][3];
        wide_t   n1 [3];
        wide_t   n2 [3];
        wide_t   nx [3];
        wide_t   dot;
        wide_t   mag;
        logic [64:0] sum;
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 3; k++) begin
                vec[i][k] = wide_t'(node_coord[p[i]][k]) - wide_t'(node_coord[p[0]][k]);
            end
        end
        cross3(vec[1], vec[2], n1);
        cross3(vec[2], vec[3], n2);
        dot = n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2];
        if (dot < 0) begin
            return 1'b0;
        end
        cross3(n1, n2, nx);
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            mag = (nx[k] < 0) ? -nx[k] : nx[k];
            // A component of 2^32 or more squares beyond 64 bits.
            if (mag >= (wide_t'(1) <<< 32)) begin
                return 1'b0;
            end
            sum = sum + 65'(mag[63:0] * mag[63:0]);
            // A running sum past 64 bits always exceeds the tolerance.
            if (sum[64]) begin
                return 1'b0;
            end
        end
        return sum[63:0] <= tolerance_sq;
    endfunction

    function automatic void sort_ids(ref id_t ids [4], input int n);
        id_t t;
        for (int i = 1; i < n; i++) begin
            for (int j = i; j > 0 && ids[j-1] > ids[j]; j--) begin
                t = ids[j];
                ids[j] = ids[j-1];
                ids[j-1] = t;
            end
        end
    endfunction

    // Works out the result of one accepted request and applies its writes.
    function automatic qfno_pkg::rsp_t predict_face_result(input qfno_pkg::req_t r);
        qfno_pkg::rsp_t res;
        id_t  ids [4];
        id_t  trial [4];
        res = '0;
        ids = '{r.node_a, r.node_b, r.node_c, r.node_d};
        if (r.req_type == qfno_pkg::REQ_WRITE) begin
            node_coord[r.node_a] = '{r.pos_x, r.pos_y, r.pos_z};
            if (!node_written[r.node_a]) begin
                written_ids.push_back(r.node_a);
            end
            node_written[r.node_a] = 1'b1;
            res.status = qfno_pkg::ST_WRITE;
            return res;
        end
        if (r.node_count < 3'd4) begin
            sort_ids(ids, 3);
            res.status = qfno_pkg::ST_TRI;
            res.out_node_a = ids[0];
            res.out_node_b = ids[1];
            res.out_node_c = ids[2];
            return res;
        end
        sort_ids(ids, 4);
        // With no passing ordering the sorted ids come back unchanged.
        res.status = qfno_pkg::ST_NONE;
        trial = ids;
        if (!ordering_is_planar(trial)) begin
            trial = '{ids[0], ids[2], ids[1], ids[3]};
            if (!ordering_is_planar(trial)) begin
                trial = '{ids[0], ids[1], ids[3], ids[2]};
                if (!ordering_is_planar(trial)) begin
                    trial = ids;
                end else begin
                    res.status = qfno_pkg::ST_QUAD;
                end
            end else begin
                res.status = qfno_pkg::ST_QUAD;
            end
        end else begin
            res.status = qfno_pkg::ST_QUAD;
        end
        res.out_node_a = trial[0];
        res.out_node_b = trial[1];
        res.out_node_c = trial[2];
        res.out_node_d = trial[3];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request sender
    // ------------------------------------------------------------------------

    // Offers one request and waits for its handshake. Between bursts the
    // valid line drops for a random gap unless the sender is held steady.
    task automatic send_request(input qfno_pkg::req_t r);
        int gap;
        if (burst_left == 0 && !sender_steady) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_results.push_back(predict_face_result(r));
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic park_sender();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
    endtask

    // Waits until every predicted result has come back, with a limit.
    task automatic wait_results_drained();
        int cycles;
        cycles = 0;
        while (pending_results.size() != 0 && cycles < 400000) begin
            @(posedge aclk);
            cycles++;
        end
        if (pending_results.size() != 0) begin
            $display("status: fail");
            $finish;
        end
    endtask

    // The tolerance may change only while the block is idle.
    task automatic write_tolerance(input logic [qfno_pkg::TOL_W-1:0] value);
        park_sender();
        wait_results_drained();
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        tolerance_sq = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------

    function automatic qfno_pkg::req_t write_req(input id_t node, input int x,
                                                 input int y, input int z);
        qfno_pkg::req_t r;
        r = '0;
        r.req_type   = qfno_pkg::REQ_WRITE;
        r.node_count = 3'($urandom_range(0, 7));
        r.node_a     = node;
        r.node_b     = id_t'($urandom);
        r.node_c     = id_t'($urandom);
        r.node_d     = id_t'($urandom);
        r.pos_x      = qfno_pkg::POS_W'(x);
        r.pos_y      = qfno_pkg::POS_W'(y);
        r.pos_z      = qfno_pkg::POS_W'(z);
        return r;
    endfunction

    function automatic qfno_pkg::req_t check_req(input int count, input id_t a,
                                                 input id_t b, input id_t c,
                                                 input id_t d);
        qfno_pkg::req_t r;
        r = '0;
        r.req_type   = qfno_pkg::REQ_CHECK;
        r.node_count = 3'(count);
        r.node_a     = a;
        r.node_b     = b;
        r.node_c     = c;
        r.node_d     = d;
        // Coordinates are ignored on a check; they still carry noise.
        r.pos_x      = qfno_pkg::POS_W'($urandom);
        r.pos_y      = qfno_pkg::POS_W'($urandom);
        r.pos_z      = qfno_pkg::POS_W'($urandom);
        return r;
    endfunction

    function automatic id_t pick_written();
        return written_ids[$urandom_range(0, written_ids.size() - 1)];
    endfunction

    // Four coplanar corners of a parallelogram, then a quad check of them
    // with the ids in random order.
    task automatic send_planar_group();
        id_t ids [4];
        int  o [3];
        int  u [3];
        int  w [3];
        int  corner;
        for (int k = 0; k < 3; k++) begin
            o[k] = $urandom_range(0, 32000) - 16000;
            u[k] = $urandom_range(0, 16000) - 8000;
            w[k] = $urandom_range(0, 16000) - 8000;
        end
        for (int i = 0; i < 4; i++) begin
            ids[i] = id_t'($urandom);
            for (int j = 0; j < i; j++) begin
                if (ids[j] == ids[i]) begin
                    ids[i] = ids[i] + 1;
                end
            end
            corner = i;
            send_request(write_req(ids[i],
                o[0] + ((corner & 1) ? u[0] : 0) + ((corner & 2) ? w[0] : 0),
                o[1] + ((corner & 1) ? u[1] : 0) + ((corner & 2) ? w[1] : 0),
                o[2] + ((corner & 1) ? u[2] : 0) + ((corner & 2) ? w[2] : 0)));
        end
        ids.shuffle();
        send_request(check_req($urandom_range(4, 7), ids[0], ids[1], ids[2], ids[3]));
    endtask

    task automatic send_random_request();
        mix_t pick;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            pick = MIX_PLANAR_GROUP;
        end else if (roll < 55) begin
            pick = MIX_POOL_QUAD;
        end else if (roll < 75) begin
            pick = MIX_TRIANGLE;
        end else begin
            pick = MIX_WRITE;
        end
        case (pick)
            MIX_PLANAR_GROUP: begin
                send_planar_group();
            end
            MIX_POOL_QUAD: begin
                send_request(check_req($urandom_range(4, 7), pick_written(),
                                       pick_written(), pick_written(), pick_written()));
            end
            MIX_TRIANGLE: begin
                send_request(check_req($urandom_range(0, 3), id_t'($urandom),
                                       id_t'($urandom), id_t'($urandom),
                                       id_t'($urandom)));
            end
            default: begin
                send_request(write_req(id_t'($urandom), $urandom, $urandom, $urandom));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-built faces: extreme ids and coordinates, both face sizes, and
    // quads that pass on the first, second and third ordering or on none.
    task automatic test_directed_faces();
        sender_steady = 1'b1;
        send_request(write_req(12'd0, -32768, -32768, -32768));
        send_request(write_req(12'hFFF, 32767, 32767, 32767));
        send_request(write_req(12'hAAA, 32767, -32768, 0));
        send_request(write_req(12'h555, -32768, 32767, 32767));
        // Triangles, unsorted, with short and three-node counts.
        send_request(check_req(3, 12'hFFF, 12'd0, 12'h800, 12'h123));
        send_request(check_req(0, 12'h555, 12'hAAA, 12'h001, 12'hFFF));
        // Quad of extreme coordinates, where the cross product is huge.
        send_request(check_req(4, 12'hFFF, 12'hAAA, 12'h555, 12'd0));
        // A square in sorted order passes at once.
        send_request(write_req(12'd10, 0, 0, 0));
        send_request(write_req(12'd11, 100, 0, 0));
        send_request(write_req(12'd12, 100, 100, 0));
        send_request(write_req(12'd13, 0, 100, 0));
        send_request(check_req(7, 12'd13, 12'd12, 12'd11, 12'd10));
        // Sorted order crosses over; the second ordering passes.
        send_request(write_req(12'd20, 0, 0, 0));
        send_request(write_req(12'd21, 100, 100, 0));
        send_request(write_req(12'd22, 100, 0, 0));
        send_request(write_req(12'd23, 0, 100, 0));
        send_request(check_req(4, 12'd20, 12'd21, 12'd22, 12'd23));
        // Only the third ordering is convex.
        send_request(write_req(12'd30, 0, 0, 0));
        send_request(write_req(12'd31, 100, 0, 0));
        send_request(write_req(12'd32, 0, 100, 0));
        send_request(write_req(12'd33, 100, 100, 0));
        send_request(check_req(5, 12'd33, 12'd30, 12'd32, 12'd31));
        // One lifted corner makes the face non-planar.
        send_request(write_req(12'd40, 0, 0, 0));
        send_request(write_req(12'd41, 100, 0, 0));
        send_request(write_req(12'd42, 100, 100, 0));
        send_request(write_req(12'd43, 0, 100, 50));
        send_request(check_req(6, 12'd40, 12'd41, 12'd42, 12'd43));
        sender_steady = 1'b0;
    endtask

    // Reruns non-planar face at tolerance 0 and max, square at 0, extreme quad at max.
    task automatic test_tolerance_extremes();
        write_tolerance('0);
        send_request(check_req(4, 12'd40, 12'd41, 12'd42, 12'd43));
        send_request(check_req(4, 12'd10, 12'd11, 12'd12, 12'd13));
        write_tolerance('1);
        send_request(check_req(4, 12'd40, 12'd41, 12'd42, 12'd43));
        send_request(check_req(4, 12'hFFF, 12'hAAA, 12'h555, 12'd0));
        write_tolerance(64'd1);
    endtask

    // Random traffic in phases, each with its own tolerance.
    task automatic test_random_traffic(input int count,
                                       input logic [qfno_pkg::TOL_W-1:0] tol);
        int sent;
        write_tolerance(tol);
        sent = 0;
        while (sent < count) begin
            send_random_request();
            sent++;
        end
    endtask

    // The receiver holds off while the sender keeps offering, so the block
    // fills and stalls its input; then the sender waits for a full drain and sends more.
    task automatic test_backpressure();
        hold_off_cycles = 3000;
        sender_steady = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_random_request();
        end
        sender_steady = 1'b0;
        park_sender();
        wait_results_drained();
        for (int i = 0; i < 8; i++) begin
            send_random_request();
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver stalls and result checker
    // ------------------------------------------------------------------------

    // The stall mode is redrawn periodically at random: always ready, random
    // stalls, or a fixed one-in-five stall.
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 300 == 0) begin
            stall_mode <= $urandom_range(0, 2);
        end
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else if (stall_mode == 0) begin
            m_ready <= 1'b1;
        end else if (stall_mode == 1) begin
            m_ready <= ($urandom_range(0, 1) == 1);
        end else begin
            m_ready <= (stall_phase % 5 != 0);
        end
    end

    always @(posedge aclk) begin
        qfno_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request waiting: %p", m_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    error_count++;
                end
                if (m_data.out_node_a !== want.out_node_a) begin
                    $error("out_node_a: expected %0d, got %0d",
                           want.out_node_a, m_data.out_node_a);
                    error_count++;
                end
                if (m_data.out_node_b !== want.out_node_b) begin
                    $error("out_node_b: expected %0d, got %0d",
                           want.out_node_b, m_data.out_node_b);
                    error_count++;
                end
                if (m_data.out_node_c !== want.out_node_c) begin
                    $error("out_node_c: expected %0d, got %0d",
                           want.out_node_c, m_data.out_node_c);
                    error_count++;
                end
                if (m_data.out_node_d !== want.out_node_d) begin
                    $error("out_node_d: expected %0d, got %0d",
                           want.out_node_d, m_data.out_node_d);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_faces();
        test_tolerance_extremes();
        test_random_traffic(125, 64'd0);
        test_backpressure();
        test_random_traffic(125, 64'd1 << 40);
        test_random_traffic(125, '1);
        test_random_traffic(125, {$urandom, $urandom});
        park_sender();
        wait_results_drained();
        repeat (1000) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard limit well beyond the slowest correct run.
    initial begin
        #60000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
